[sv/wgm_pkg.sv]
// shared types, constants and helpers for the wildcard glob matcher
`default_nettype none

package wgm_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int CFG_ADDR_W      = 5;
  localparam int CFG_DATA_W      = 64;
  localparam int LENGTH_W        = 5;
  localparam int CHAR_W          = 8;

  localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CHAR_QMARK = 8'h3F;
  localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

  typedef enum logic [1:0] {
    REG_PAT_LOW   = 2'd0,
    REG_PAT_HIGH  = 2'd1,
    REG_PAT_LEN   = 2'd2,
    REG_LEAD_STAR = 2'd3
  } reg_idx_t;

  // carried from each cell to its right neighbor
  typedef struct packed {
    logic step;   // literal or '?' matched, enter next position
    logic carry;  // star closure ripple
    logic start;  // start set closure ripple
  } wgm_link_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic              advance;
    logic              restart;
    logic              lead_star;
    logic [CHAR_W-1:0] text_char;
  } wgm_ctrl_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] res;
    res = c;
    if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      res = c + CASE_DELTA;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/wildcard_glob_matcher.sv]
// top level of the wildcard glob matcher: config registers, cell row, result register
// usage
//   a string is streamed in, one byte per request on the in_ channel; the
//   final byte carries in_last_char, and an empty string is a single request
//   with in_empty_string set (its text byte and last flag are ignored)
//   one result request leaves on the out_ channel per string: out_matched is
//   1 when the whole string matches the pattern
//   the pattern ('*' any run, '?' one byte, other bytes case-folded for A-Z)
//   and its length are written over the cfg_ apb port, 64-bit registers at
//   byte addresses 0, 8, 16, 24; any write restarts the string in progress
// timing
//   one request per cycle when not stalled; a row of cells, one per position,
//   settles the new state in the same cycle with the star closure rippling
//   from cell to cell; the result appears in the cycle after the string ends
// stall
//   a result waits in the output register while out_stall is high; input
//   requests are stalled only while that register is full and stalled
// reset
//   synchronous, active low; clears the pattern, length zero, leading
//   wildcard set, and returns the state to the start set
`default_nettype none

module wildcard_glob_matcher #(
  parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input requests
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [wgm_pkg::CHAR_W-1:0]    in_text_char,
  input  wire logic                          in_last_char,
  input  wire logic                          in_empty_string,
  // result requests
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_matched,
  // configuration
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [wgm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [wgm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [wgm_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  localparam int NPOS  = PATTERN_MAX + 1;
  localparam int POS_W = $clog2(NPOS);

  // configuration registers
  logic [wgm_pkg::CFG_DATA_W-1:0] pat_low_r,  pat_low_nxt;
  logic [wgm_pkg::CFG_DATA_W-1:0] pat_high_r, pat_high_nxt;
  logic [wgm_pkg::LENGTH_W-1:0]   pat_len_r,  pat_len_nxt;
  logic                           lead_star_r, lead_star_nxt;

  logic               cfg_wr;
  wgm_pkg::reg_idx_t  cfg_idx;

  // string state control
  logic restart_r, restart_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_matched_r, out_matched_nxt;

  logic in_acc;
  logic out_acc;
  logic str_end;

  logic [POS_W-1:0] eff_len;
  logic [2*wgm_pkg::CFG_DATA_W-1:0] pat_all;

  wgm_pkg::wgm_ctrl_t ctrl;
  wgm_pkg::wgm_link_t link [NPOS];

  logic [NPOS-1:0] pos_en;
  logic [NPOS-1:0] cur_state;
  logic [NPOS-1:0] nxt_state;
  logic [NPOS-1:0] start_state;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = wgm_pkg::reg_idx_t'(cfg_paddr[4:3]);

  // register write decode
  always_comb begin
    pat_low_nxt   = pat_low_r;
    pat_high_nxt  = pat_high_r;
    pat_len_nxt   = pat_len_r;
    lead_star_nxt = lead_star_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        wgm_pkg::REG_PAT_LOW:   pat_low_nxt   = cfg_pwdata;
        wgm_pkg::REG_PAT_HIGH:  pat_high_nxt  = cfg_pwdata;
        wgm_pkg::REG_PAT_LEN:   pat_len_nxt   = cfg_pwdata[wgm_pkg::LENGTH_W-1:0];
        wgm_pkg::REG_LEAD_STAR: lead_star_nxt = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    unique case (cfg_idx)
      wgm_pkg::REG_PAT_LOW:   cfg_prdata = pat_low_r;
      wgm_pkg::REG_PAT_HIGH:  cfg_prdata = pat_high_r;
      wgm_pkg::REG_PAT_LEN:   cfg_prdata = wgm_pkg::CFG_DATA_W'(pat_len_r);
      wgm_pkg::REG_LEAD_STAR: cfg_prdata = wgm_pkg::CFG_DATA_W'(lead_star_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // lengths beyond the cell row behave as the full row
  always_comb begin
    if (pat_len_r > wgm_pkg::LENGTH_W'(PATTERN_MAX)) begin
      eff_len = POS_W'(PATTERN_MAX);
    end else begin
      eff_len = pat_len_r[POS_W-1:0];
    end
  end

  assign pat_all = {pat_high_r, pat_low_r};

  // handshakes: inputs wait only while a finished result is held
  assign out_acc  = out_valid_r & ~out_stall;
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign str_end  = in_acc & (in_empty_string | in_last_char);

  assign ctrl.advance   = in_acc & ~in_empty_string;
  assign ctrl.restart   = restart_r;
  assign ctrl.lead_star = lead_star_r;
  assign ctrl.text_char = in_text_char;

  assign link[0] = '0;

  // row of cells, one per pattern position plus the final (all matched) position
  for (genvar gi = 0; gi < NPOS; gi++) begin : g_cell
    logic [wgm_pkg::CHAR_W-1:0] cell_char;

    assign pos_en[gi] = (POS_W'(gi) < eff_len);

    if (gi < PATTERN_MAX) begin : g_char
      assign cell_char = pat_all[gi*wgm_pkg::CHAR_W +: wgm_pkg::CHAR_W];
    end else begin : g_nochar
      assign cell_char = '0;
    end

    if (gi < NPOS - 1) begin : g_mid
      wgm_cell #(
        .IS_FIRST (gi == 0)
      ) u_cell (
        .clk       (clk),
        .enable    (pos_en[gi]),
        .pat_char  (cell_char),
        .ctrl      (ctrl),
        .link_i    (link[gi]),
        .link_o    (link[gi+1]),
        .cur_bit   (cur_state[gi]),
        .nxt_bit   (nxt_state[gi]),
        .start_bit (start_state[gi])
      );
    end else begin : g_last
      // nothing lies right of the final position
      wgm_cell #(
        .IS_FIRST (gi == 0)
      ) u_cell (
        .clk       (clk),
        .enable    (pos_en[gi]),
        .pat_char  (cell_char),
        .ctrl      (ctrl),
        .link_i    (link[gi]),
        .link_o    (),
        .cur_bit   (cur_state[gi]),
        .nxt_bit   (nxt_state[gi]),
        .start_bit (start_state[gi])
      );
    end
  end

  // restart flag stands in for the start set until the next byte
  always_comb begin
    restart_nxt = restart_r;
    if (cfg_wr || str_end) begin
      restart_nxt = 1'b1;
    end else if (in_acc) begin
      restart_nxt = 1'b0;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_matched_nxt = out_matched_r;
    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
    if (str_end) begin
      out_valid_nxt   = 1'b1;
      out_matched_nxt = in_empty_string ? start_state[eff_len] : nxt_state[eff_len];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r   <= '0;
      pat_high_r  <= '0;
      pat_len_r   <= '0;
      lead_star_r <= 1'b1;
      restart_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      pat_low_r   <= pat_low_nxt;
      pat_high_r  <= pat_high_nxt;
      pat_len_r   <= pat_len_nxt;
      lead_star_r <= lead_star_nxt;
      restart_r   <= restart_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_matched_r <= out_matched_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

  // no position beyond the pattern end is ever active
  a_no_pos_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((cur_state >> eff_len) >> 1) == '0)
    else $error("active position beyond pattern end");

  // the start position is always active right after a restart
  a_restart_start: assert property (@(posedge clk) disable iff (!rst_n)
    restart_r |-> cur_state[0])
    else $error("start position missing after restart");

  // implied leading star keeps position zero alive across bytes
  a_lead_star_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_empty_string && !in_last_char && lead_star_r && cur_state[0])
      |=> cur_state[0])
    else $error("leading wildcard lost position zero");

  // every string end produces a result request
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    str_end |=> out_valid_r)
    else $error("string end without result");

endmodule

`default_nettype wire

[sv/wgm_cell.sv]
// one pattern position of the matcher: state bit, compare and closure links
`default_nettype none

module wgm_cell #(
  parameter bit IS_FIRST = 1'b0
) (
  input  wire logic                      clk,
  input  wire logic                      enable,
  input  wire logic [wgm_pkg::CHAR_W-1:0] pat_char,
  input  wire wgm_pkg::wgm_ctrl_t        ctrl,
  input  wire wgm_pkg::wgm_link_t        link_i,
  output wgm_pkg::wgm_link_t             link_o,
  output logic                           cur_bit,
  output logic                           nxt_bit,
  output logic                           start_bit
);

  logic active_r;
  logic is_star;
  logic hit;
  logic pre;

  assign is_star   = (pat_char == wgm_pkg::CHAR_STAR);
  assign hit       = (pat_char == wgm_pkg::CHAR_QMARK) ||
                     (wgm_pkg::fold_case(pat_char) == wgm_pkg::fold_case(ctrl.text_char));
  assign start_bit = IS_FIRST | link_i.start;
  assign cur_bit   = ctrl.restart ? start_bit : active_r;

  // star holds its own position, implied leading star holds position zero
  assign pre     = (enable & cur_bit & is_star) | link_i.step |
                   (IS_FIRST & ctrl.lead_star & cur_bit);
  assign nxt_bit = pre | link_i.carry;

  assign link_o.step  = enable & cur_bit & ~is_star & hit;
  assign link_o.carry = enable & nxt_bit & is_star;
  assign link_o.start = enable & start_bit & is_star;

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      active_r <= nxt_bit;
    end
  end

endmodule

`default_nettype wire
